[rtl/core/ecint_pkg.sv]
// Shared types and constants of the easing curve interpolator.
package ecint_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int Q_WIDTH     = FRAC_BITS + 1;
  localparam int CURVE_WIDTH = 3;

  // progress and easing values, unsigned Q1.16 with 1.0 representable
  typedef logic [Q_WIDTH-1:0]     qval_t;
  typedef logic [CURVE_WIDTH-1:0] curve_t;

  localparam qval_t Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam curve_t CURVE_LINEAR       = 3'd0;
  localparam curve_t CURVE_IN_QUAD      = 3'd1;
  localparam curve_t CURVE_OUT_QUAD     = 3'd2;
  localparam curve_t CURVE_IN_OUT_QUAD  = 3'd3;
  localparam curve_t CURVE_IN_CUBIC     = 3'd4;
  localparam curve_t CURVE_OUT_CUBIC    = 3'd5;
  localparam curve_t CURVE_IN_OUT_CUBIC = 3'd6;

endpackage

[rtl/core/ecint_div.sv]
// Pipelined progress divider: t = elapsed / duration as Q1.16, one quotient bit per stage.
module ecint_div
  import ecint_pkg::*;
#(
  parameter int TIME_WIDTH = 16,
  parameter int SIDE_WIDTH = 35
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [TIME_WIDTH-1:0] elapsed,
  input  logic [TIME_WIDTH-1:0] duration,
  input  logic [SIDE_WIDTH-1:0] side_in,
  output logic                  out_valid,
  output qval_t                 t,
  output logic [SIDE_WIDTH-1:0] side_out
);

  localparam int STEPS = FRAC_BITS;

  logic [STEPS:0]          vld;
  logic [STEPS:0]          fin;
  logic [TIME_WIDTH-1:0]   rem  [0:STEPS];
  logic [TIME_WIDTH-1:0]   dvs  [0:STEPS];
  logic [FRAC_BITS-1:0]    quo  [0:STEPS];
  logic [SIDE_WIDTH-1:0]   side [0:STEPS];

  // input stage; a finished animation skips the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= elapsed;
      dvs[0]  <= duration;
      quo[0]  <= '0;
      fin[0]  <= (duration == '0) || (elapsed >= duration);
      side[0] <= side_in;
    end
  end

  // restoring division; remainder stays below the divisor when not finished
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [TIME_WIDTH:0] shl;
    logic [TIME_WIDTH:0] dif;
    logic                ge;

    assign shl = {rem[i], 1'b0};
    assign dif = shl - {1'b0, dvs[i]};
    assign ge  = !dif[TIME_WIDTH];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? dif[TIME_WIDTH-1:0] : shl[TIME_WIDTH-1:0];
        dvs[i+1]  <= dvs[i];
        quo[i+1]  <= {quo[i][FRAC_BITS-2:0], ge};
        fin[i+1]  <= fin[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign t         = fin[STEPS] ? Q_ONE : {1'b0, quo[STEPS]};
  assign side_out  = side[STEPS];

endmodule

[rtl/core/ecint_blend.sv]
// Easing curve evaluation and start/end blend, five register stages.
module ecint_blend
  import ecint_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  qval_t                         t,
  input  curve_t                        curve,
  input  logic signed [VALUE_WIDTH-1:0] start_value,
  input  logic signed [VALUE_WIDTH-1:0] end_value,
  output logic                          out_valid,
  output logic [VALUE_WIDTH-1:0]        eased_value
);

  localparam int SQ_WIDTH   = 2 * Q_WIDTH;
  localparam int CU_WIDTH   = 3 * Q_WIDTH;
  localparam int QS_WIDTH   = SQ_WIDTH + 1;
  localparam int CS_WIDTH   = CU_WIDTH + 2;
  localparam int DIFF_WIDTH = VALUE_WIDTH + 1;
  localparam int PROD_WIDTH = DIFF_WIDTH + Q_WIDTH + 1;
  localparam int ACC_WIDTH  = VALUE_WIDTH + FRAC_BITS + 4;

  logic [5:1] vld;

  // stage 1: curve decode, operand select
  qval_t                        u;
  qval_t                        x_sel;
  logic                         flip_sel;
  logic                         cubic_sel;
  logic                         lin_sel;
  logic [1:0]                   sh_sel;
  logic                         early_half;

  assign u          = Q_ONE - t;
  assign early_half = (t[Q_WIDTH-1:Q_WIDTH-2] == 2'b00);

  always_comb begin
    x_sel     = t;
    flip_sel  = 1'b0;
    cubic_sel = 1'b0;
    lin_sel   = 1'b0;
    sh_sel    = 2'd0;
    case (curve)
      CURVE_IN_QUAD: begin
      end
      CURVE_OUT_QUAD: begin
        x_sel    = u;
        flip_sel = 1'b1;
      end
      CURVE_IN_OUT_QUAD: begin
        x_sel    = early_half ? t : u;
        flip_sel = !early_half;
        sh_sel   = 2'd1;
      end
      CURVE_IN_CUBIC: begin
        cubic_sel = 1'b1;
      end
      CURVE_OUT_CUBIC: begin
        x_sel     = u;
        flip_sel  = 1'b1;
        cubic_sel = 1'b1;
      end
      CURVE_IN_OUT_CUBIC: begin
        x_sel     = early_half ? t : u;
        flip_sel  = !early_half;
        cubic_sel = 1'b1;
        sh_sel    = 2'd2;
      end
      default: begin
        lin_sel = 1'b1;
      end
    endcase
  end

  qval_t                         x1, x2, x3;
  logic                          flip1, flip2, flip3;
  logic                          cubic1, cubic2, cubic3;
  logic                          lin1, lin2, lin3;
  logic [1:0]                    sh1, sh2, sh3;
  logic signed [VALUE_WIDTH-1:0] start1, start2, start3, start4, start5;
  logic signed [DIFF_WIDTH-1:0]  diff1, diff2, diff3, diff4;
  logic [SQ_WIDTH-1:0]           sq2, sq3;
  logic [CU_WIDTH-1:0]           cube3;
  qval_t                         f4;
  logic signed [PROD_WIDTH-1:0]  prod5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1     <= x_sel;
      flip1  <= flip_sel;
      cubic1 <= cubic_sel;
      lin1   <= lin_sel;
      sh1    <= sh_sel;
      start1 <= start_value;
      diff1  <= DIFF_WIDTH'(end_value) - DIFF_WIDTH'(start_value);
    end
  end

  // stage 2: square
  always_ff @(posedge clk) begin
    if (en) begin
      sq2    <= SQ_WIDTH'(x1) * SQ_WIDTH'(x1);
      x2     <= x1;
      flip2  <= flip1;
      cubic2 <= cubic1;
      lin2   <= lin1;
      sh2    <= sh1;
      start2 <= start1;
      diff2  <= diff1;
    end
  end

  // stage 3: cube
  always_ff @(posedge clk) begin
    if (en) begin
      cube3  <= CU_WIDTH'(sq2) * CU_WIDTH'(x2);
      sq3    <= sq2;
      x3     <= x2;
      flip3  <= flip2;
      cubic3 <= cubic2;
      lin3   <= lin2;
      sh3    <= sh2;
      start3 <= start2;
      diff3  <= diff2;
    end
  end

  // stage 4: scale by 1, 2 or 4, round once, mirror out and late in-out
  logic [QS_WIDTH-1:0] qsum;
  logic [CS_WIDTH-1:0] csum;
  qval_t               g;
  qval_t               f_sel;

  assign qsum = (QS_WIDTH'(sq3) << sh3) + (QS_WIDTH'(1) << (FRAC_BITS - 1));
  assign csum = (CS_WIDTH'(cube3) << sh3) + (CS_WIDTH'(1) << (2 * FRAC_BITS - 1));

  always_comb begin
    if (cubic3) begin
      g = csum[2*FRAC_BITS +: Q_WIDTH];
    end else begin
      g = qsum[FRAC_BITS +: Q_WIDTH];
    end
    if (lin3) begin
      f_sel = x3;
    end else if (flip3) begin
      f_sel = Q_ONE - g;
    end else begin
      f_sel = g;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4     <= f_sel;
      start4 <= start3;
      diff4  <= diff3;
    end
  end

  // stage 5: span times easing
  logic signed [Q_WIDTH:0] f_s;

  assign f_s = {1'b0, f4};

  always_ff @(posedge clk) begin
    if (en) begin
      prod5  <= PROD_WIDTH'(diff4) * PROD_WIDTH'(f_s);
      start5 <= start4;
    end
  end

  // final add and round; result lies between start and end
  logic signed [ACC_WIDTH-1:0] acc;

  assign acc = (ACC_WIDTH'(start5) <<< FRAC_BITS) + ACC_WIDTH'(prod5)
             + (ACC_WIDTH'(1) <<< (FRAC_BITS - 1));

  assign out_valid   = vld[5];
  assign eased_value = acc[FRAC_BITS +: VALUE_WIDTH];

endmodule

[rtl/core/easing_curve_interpolator_unit.sv]
// Easing curve interpolator top level: stream ports, pipeline and output buffer.
//
// Input items arrive on s_tvalid/s_tready with the curve code in s_tuser and
// elapsed, duration, start and end values in s_tdata. Each item gives one
// result on m_tvalid/m_tready: start + (end - start) * f(elapsed/duration),
// rounded, where f is linear or a quadratic or cubic in, out or in-out curve.
// Elapsed past the duration, or a zero duration, gives the end value.
//
// Throughput: one item per cycle unless the receiver stalls. From acceptance
// to m_tvalid an item passes an input register, sixteen restoring-division stages
// for the Q1.16 progress, five easing and blend stages, and the output register.
//
// Reset clears all valid bits; no payload is cleared. When the receiver
// stalls, a finished item waits in the output register and one more is
// caught in a skid register; only once the skid register is occupied does
// s_tready drop and the whole pipeline hold, so nothing is lost or repeated.
module easing_curve_interpolator_unit
  import ecint_pkg::*;
#(
  parameter int TIME_WIDTH  = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // elapsed, duration, start_value, end_value (lowest first), zero padded
  input  logic [((2*TIME_WIDTH+2*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
  // curve_type
  input  logic [CURVE_WIDTH-1:0]                        s_tuser,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // eased_value, zero padded
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]              m_tdata
);

  localparam int OUT_DW     = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int DUR_LSB    = TIME_WIDTH;
  localparam int START_LSB  = 2 * TIME_WIDTH;
  localparam int END_LSB    = 2 * TIME_WIDTH + VALUE_WIDTH;
  localparam int SIDE_WIDTH = CURVE_WIDTH + 2 * VALUE_WIDTH;

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  logic [SIDE_WIDTH-1:0] side_in;
  logic [SIDE_WIDTH-1:0] side_out;
  logic                  div_valid;
  qval_t                 div_t;

  assign side_in = {s_tuser, s_tdata[END_LSB +: VALUE_WIDTH],
                    s_tdata[START_LSB +: VALUE_WIDTH]};

  ecint_div #(
    .TIME_WIDTH (TIME_WIDTH),
    .SIDE_WIDTH (SIDE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .elapsed   (s_tdata[0 +: TIME_WIDTH]),
    .duration  (s_tdata[DUR_LSB +: TIME_WIDTH]),
    .side_in   (side_in),
    .out_valid (div_valid),
    .t         (div_t),
    .side_out  (side_out)
  );

  logic                   blend_valid;
  logic [VALUE_WIDTH-1:0] blend_value;

  ecint_blend #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_blend (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (div_valid),
    .t           (div_t),
    .curve       (side_out[2*VALUE_WIDTH +: CURVE_WIDTH]),
    .start_value (side_out[0 +: VALUE_WIDTH]),
    .end_value   (side_out[VALUE_WIDTH +: VALUE_WIDTH]),
    .out_valid   (blend_valid),
    .eased_value (blend_value)
  );

  // output register plus one skid entry
  logic                   push;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [VALUE_WIDTH-1:0] skid_value;

  assign push     = en && blend_valid;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      m_tvalid   <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_value <= skid_valid ? skid_value : blend_value;
    end else if (push) begin
      skid_value <= blend_value;
    end
  end

  assign m_tdata = OUT_DW'(out_value);

endmodule
